[hw/rtl/sync_framed_packet_receiver_assert.svh]
`ifndef SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFPR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");
`define SFPR_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: label");
`define SFPR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: label");
`else
`define SFPR_ASSERT_ALWAYS(label, clk, rst, cond)
`define SFPR_ASSERT_IMPLY(label, clk, rst, pre, post)
`define SFPR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[hw/rtl/sfpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sfpr_pkg;
   localparam int FRAME_BUFFER_BYTES = 512;
   localparam int BUF_AW = $clog2(FRAME_BUFFER_BYTES);
   localparam int CNT_W = BUF_AW + 1;
   localparam int HDR_BYTES = 11;
   localparam int MAX_PAYLOAD = FRAME_BUFFER_BYTES - HDR_BYTES;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GOOD = 3'd1;
   localparam logic [2:0] ST_CRC_BAD = 3'd2;
   localparam logic [2:0] ST_LEN_BIG = 3'd3;
   localparam logic [2:0] ST_SYNC_BAD = 3'd4;
   localparam logic [2:0] ST_IGNORED = 3'd5;

   localparam logic CSR_FIRST_SYNC = 1'b0;
   localparam logic CSR_SECOND_SYNC = 1'b1;

   localparam logic [7:0] FIRST_SYNC_RESET = 8'hAA;
   localparam logic [7:0] SECOND_SYNC_RESET = 8'h55;

   function automatic logic [15:0] sfpr_crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction
endpackage
`default_nettype wire

[hw/rtl/sfpr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sfpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[hw/rtl/sync_framed_packet_receiver.sv]
// Channel   Direction  Handshake              Contents
// req       in         req_tvalid/req_tready  tuser: action; tdata: data_byte, read_index
// rsp       out        rsp_tvalid/rsp_tready  tuser: status; tdata: header fields, read_data
// csr       in         csr_we                 csr_addr selects a sync byte, csr_wdata its value
//
// One request per cycle while the response side can take it; its response appears in the cycle after acceptance.
// The payload buffer is a single-port-write, registered-read RAM; reads and
// writes never target it in the same cycle, so no forwarding is needed.
// A stalled response holds the request side only while the response register is full.
// Synchronous reset returns the parser to the sync hunt; the buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sync_framed_packet_receiver_assert.svh"
module sync_framed_packet_receiver
   import sfpr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   // [7:0] data_byte, [16:8] read_index, [23:17] zero
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] status
   output logic      [2:0]  rsp_tuser,
   // [0] holding, [8:1] version, [16:9] packet_type, [24:17] service_bits,
   // [40:25] packet_id, [49:41] payload_length, [57:50] read_data, [63:58] zero
   output logic      [63:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_HEADER = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_HOLD = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       version_ff, version_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       service_ff, service_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      length_ff, length_in;
   logic [15:0]      fcs_ff, fcs_in;
   logic [7:0]       sync1_ff, sync2_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic [2:0]       s1_status_ff, s1_status_in;
   logic             s1_hold_ff, s1_hold_in;
   logic             s1_rd_ff, s1_rd_in;

   logic              req_fire;
   logic [1:0]        action;
   logic [7:0]        data_byte;
   logic [8:0]        read_index;
   logic [15:0]       crc_step;
   logic [15:0]       crc_first;
   logic [15:0]       pay_next;
   logic [15:0]       fcs_full;
   logic              ram_we;
   logic              ram_re;
   logic [BUF_AW-1:0] ram_waddr;
   logic [7:0]        ram_rdata;
   logic              hold_status_ok;
   logic              good_fire;

   assign action = req_tuser;
   assign data_byte = req_tdata[7:0];
   assign read_index = req_tdata[16:8];
   assign req_tready = !s1_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   assign crc_step = sfpr_crc_byte(crc_ff, data_byte);
   assign crc_first = sfpr_crc_byte(CRC_INIT, data_byte);
   assign pay_next = 16'(count_ff) - 16'(HDR_BYTES) + 16'd1;
   assign fcs_full = {data_byte, fcs_ff[7:0]};
   assign ram_waddr = BUF_AW'(count_ff - CNT_W'(HDR_BYTES));

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      crc_in = crc_ff;
      version_in = version_ff;
      type_in = type_ff;
      service_in = service_ff;
      id_in = id_ff;
      length_in = length_ff;
      fcs_in = fcs_ff;
      s1_status_in = ST_IDLE;
      ram_we = 1'b0;
      ram_re = 1'b0;
      if (req_fire) begin
         case (action)
            ACT_PUSH: begin
               case (phase_ff)
                  PH_SYNC1: begin
                     if (data_byte == sync1_ff) begin
                        crc_in = crc_first;
                        count_in = CNT_W'(1);
                        phase_in = PH_SYNC2;
                     end
                  end
                  PH_SYNC2: begin
                     if (data_byte == sync2_ff) begin
                        crc_in = crc_step;
                        count_in = CNT_W'(2);
                        phase_in = PH_HEADER;
                     end else begin
                        phase_in = PH_SYNC1;
                        count_in = '0;
                        crc_in = CRC_INIT;
                        s1_status_in = ST_SYNC_BAD;
                     end
                  end
                  PH_HEADER: begin
                     count_in = count_ff + CNT_W'(1);
                     if (count_ff <= CNT_W'(8)) begin
                        crc_in = crc_step;
                     end
                     case (count_ff)
                        CNT_W'(2): version_in = data_byte;
                        CNT_W'(3): type_in = data_byte;
                        CNT_W'(4): service_in = data_byte;
                        CNT_W'(5): id_in[7:0] = data_byte;
                        CNT_W'(6): id_in[15:8] = data_byte;
                        CNT_W'(7): length_in[7:0] = data_byte;
                        CNT_W'(8): length_in[15:8] = data_byte;
                        CNT_W'(9): fcs_in[7:0] = data_byte;
                        default: fcs_in[15:8] = data_byte;
                     endcase
                     if (count_ff >= CNT_W'(HDR_BYTES - 1)) begin
                        if (length_ff > 16'(MAX_PAYLOAD)) begin
                           phase_in = PH_SYNC1;
                           count_in = '0;
                           crc_in = CRC_INIT;
                           s1_status_in = ST_LEN_BIG;
                        end else if (length_ff == 16'd0) begin
                           if (crc_ff == fcs_full) begin
                              phase_in = PH_HOLD;
                              s1_status_in = ST_GOOD;
                           end else begin
                              phase_in = PH_SYNC1;
                              count_in = '0;
                              crc_in = CRC_INIT;
                              s1_status_in = ST_CRC_BAD;
                           end
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     ram_we = 1'b1;
                     crc_in = crc_step;
                     count_in = count_ff + CNT_W'(1);
                     if (pay_next >= length_ff) begin
                        if (crc_step == fcs_ff) begin
                           phase_in = PH_HOLD;
                           s1_status_in = ST_GOOD;
                        end else begin
                           phase_in = PH_SYNC1;
                           count_in = '0;
                           crc_in = CRC_INIT;
                           s1_status_in = ST_CRC_BAD;
                        end
                     end
                  end
                  PH_HOLD: begin
                     s1_status_in = ST_IGNORED;
                  end
                  default: begin
                     phase_in = PH_SYNC1;
                     count_in = '0;
                     crc_in = CRC_INIT;
                  end
               endcase
            end
            ACT_READ: begin
               if (phase_ff == PH_HOLD && 16'(read_index) < length_ff
                   && 32'(read_index) < FRAME_BUFFER_BYTES) begin
                  ram_re = 1'b1;
               end
            end
            ACT_RELEASE: begin
               phase_in = PH_SYNC1;
               count_in = '0;
               crc_in = CRC_INIT;
            end
            default: begin
            end
         endcase
      end
      s1_hold_in = (phase_in == PH_HOLD);
      s1_rd_in = ram_re;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         count_ff <= '0;
         crc_ff <= CRC_INIT;
         sync1_ff <= FIRST_SYNC_RESET;
         sync2_ff <= SECOND_SYNC_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff <= crc_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_we && csr_addr == CSR_FIRST_SYNC) begin
            sync1_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == CSR_SECOND_SYNC) begin
            sync2_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      version_ff <= version_in;
      type_ff <= type_in;
      service_ff <= service_in;
      id_ff <= id_in;
      length_ff <= length_in;
      fcs_ff <= fcs_in;
      if (req_fire) begin
         s1_status_ff <= s1_status_in;
         s1_hold_ff <= s1_hold_in;
         s1_rd_ff <= s1_rd_in;
      end
   end

   sfpr_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BUFFER_BYTES)
   ) u_payload_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(data_byte),
      .re(ram_re),
      .raddr(BUF_AW'(read_index)),
      .rdata(ram_rdata)
   );

   assign rsp_tvalid = s1_valid_ff;
   assign rsp_tuser = s1_status_ff;
   assign rsp_tdata[0] = s1_hold_ff;
   assign rsp_tdata[8:1] = s1_hold_ff ? version_ff : 8'd0;
   assign rsp_tdata[16:9] = s1_hold_ff ? type_ff : 8'd0;
   assign rsp_tdata[24:17] = s1_hold_ff ? service_ff : 8'd0;
   assign rsp_tdata[40:25] = s1_hold_ff ? id_ff : 16'd0;
   assign rsp_tdata[49:41] = s1_hold_ff ? length_ff[8:0] : 9'd0;
   assign rsp_tdata[57:50] = s1_rd_ff ? ram_rdata : 8'd0;
   assign rsp_tdata[63:58] = 6'd0;

   assign hold_status_ok = s1_status_ff inside {ST_IDLE, ST_GOOD, ST_IGNORED};
   assign good_fire = req_fire && s1_status_in == ST_GOOD;

   `SFPR_ASSERT_IMPLY(a_write_in_payload, clock, reset, ram_we, phase_ff == PH_PAYLOAD)
   `SFPR_ASSERT_IMPLY(a_read_in_hold, clock, reset, ram_re, phase_ff == PH_HOLD && !ram_we)
   `SFPR_ASSERT_IMPLY(a_hold_status, clock, reset, s1_valid_ff && s1_hold_ff, hold_status_ok)
   `SFPR_ASSERT_NEXT(a_good_enters_hold, clock, reset, good_fire, phase_ff == PH_HOLD)
endmodule
`default_nettype wire

[bench/sync_framed_packet_receiver_tb.sv]
`timescale 1ns / 1ps
module sync_framed_packet_receiver_tb;
   import sfpr_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int ITEM_GOAL = 1850;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {FLAW_NONE, FLAW_CHECK, FLAW_SYNC, FLAW_LENGTH} frame_flaw_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        holding;
      logic [7:0]  version;
      logic [7:0]  packet_type;
      logic [7:0]  service_bits;
      logic [15:0] packet_id;
      logic [8:0]  payload_length;
      logic [7:0]  read_data;
   } rx_result_type;

   class frame_scoreboard;
      typedef enum logic [2:0] {HUNT_FIRST, HUNT_SECOND, IN_HEADER, IN_PAYLOAD, HOLDING} phase_type;

      logic [7:0]    sync_a = FIRST_SYNC_RESET;
      logic [7:0]    sync_b = SECOND_SYNC_RESET;
      phase_type     phase = HUNT_FIRST;
      int unsigned   count = 0;
      logic [15:0]   crc = CRC_INIT;
      logic [63:0]   hdr = '0;
      logic [15:0]   fcs = '0;
      logic [7:0]    store [FRAME_BUFFER_BYTES];
      rx_result_type pending [$];
      int            errors = 0;
      int            seen = 0;

      function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
               c = c ^ 16'h1021;
            end
         end
         return c;
      endfunction

      function void set_reg(logic addr, logic [7:0] value);
         if (addr == CSR_FIRST_SYNC) begin
            sync_a = value;
         end else begin
            sync_b = value;
         end
      endfunction

      function void restart();
         phase = HUNT_FIRST;
         count = 0;
         crc = CRC_INIT;
      endfunction

      function int unsigned frame_len();
         return 32'(hdr[55:40]);
      endfunction

      function logic [2:0] close_frame();
         if (crc == fcs) begin
            phase = HOLDING;
            return ST_GOOD;
         end
         restart();
         return ST_CRC_BAD;
      endfunction

      function logic [2:0] take_byte(logic [7:0] b);
         logic [2:0] st;
         int unsigned k;
         st = ST_IDLE;
         case (phase)
            HUNT_FIRST: begin
               if (b == sync_a) begin
                  crc = crc_next(CRC_INIT, b);
                  count = 1;
                  hdr = '0;
                  fcs = '0;
                  phase = HUNT_SECOND;
               end
            end
            HUNT_SECOND: begin
               if (b == sync_b) begin
                  crc = crc_next(crc, b);
                  count = 2;
                  phase = IN_HEADER;
               end else begin
                  restart();
                  st = ST_SYNC_BAD;
               end
            end
            IN_HEADER: begin
               if (count <= 8) begin
                  crc = crc_next(crc, b);
                  hdr[8 * (count - 2) +: 8] = b;
               end else if (count == 9) begin
                  fcs[7:0] = b;
               end else begin
                  fcs[15:8] = b;
               end
               count++;
               if (count >= HDR_BYTES) begin
                  if (frame_len() > MAX_PAYLOAD) begin
                     restart();
                     st = ST_LEN_BIG;
                  end else if (frame_len() == 0) begin
                     st = close_frame();
                  end else begin
                     phase = IN_PAYLOAD;
                  end
               end
            end
            IN_PAYLOAD: begin
               k = count - HDR_BYTES;
               if (k < FRAME_BUFFER_BYTES) begin
                  store[k] = b;
               end
               crc = crc_next(crc, b);
               count++;
               if (count - HDR_BYTES >= frame_len()) begin
                  st = close_frame();
               end
            end
            default: begin
               st = ST_IGNORED;
            end
         endcase
         return st;
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] b, logic [8:0] idx);
         rx_result_type r;
         r = '0;
         case (act)
            ACT_PUSH: begin
               r.status = take_byte(b);
            end
            ACT_READ: begin
               if (phase == HOLDING && idx < frame_len()) begin
                  r.read_data = store[idx];
               end
            end
            ACT_RELEASE: begin
               restart();
            end
            default: begin
            end
         endcase
         if (phase == HOLDING) begin
            r.holding = 1'b1;
            r.version = hdr[7:0];
            r.packet_type = hdr[15:8];
            r.service_bits = hdr[23:16];
            r.packet_id = hdr[39:24];
            r.payload_length = hdr[48:40];
         end
         pending.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         if (errors < 100) begin
            $display("mismatch on response %0d, %s: got %0h, expected %0h", seen, what, got,
                     want);
         end
         errors++;
      endtask

      task check_response(logic [2:0] st, logic [63:0] d);
         rx_result_type want;
         seen++;
         if (pending.size() == 0) begin
            report("unexpected response", st, 0);
            return;
         end
         want = pending.pop_front();
         if (st !== want.status) report("status", st, want.status);
         if (d[0] !== want.holding) report("holding", d[0], want.holding);
         if (d[8:1] !== want.version) report("version", d[8:1], want.version);
         if (d[16:9] !== want.packet_type) report("packet_type", d[16:9], want.packet_type);
         if (d[24:17] !== want.service_bits) report("service_bits", d[24:17], want.service_bits);
         if (d[40:25] !== want.packet_id) report("packet_id", d[40:25], want.packet_id);
         if (d[49:41] !== want.payload_length) begin
            report("payload_length", d[49:41], want.payload_length);
         end
         if (d[57:50] !== want.read_data) report("read_data", d[57:50], want.read_data);
      endtask

      task leftover_check();
         if (pending.size() != 0) begin
            report("responses still missing", 0, pending.size());
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;
   logic [63:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic [7:0]  csr_wdata;

   frame_scoreboard sb;
   bit quiet = 1'b0;
   int items_sent = 0;
   int cycles = 0;

   sync_framed_packet_receiver uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sync_framed_packet_receiver_tb: done, errors");
         $finish;
      end
   end

   task automatic send_req(input logic [1:0] act, input logic [7:0] b, input logic [8:0] idx);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {7'd0, idx, b};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, b, idx);
      if (act != ACT_NONE) begin
         items_sent++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      send_req(ACT_PUSH, b, 9'($urandom_range(0, 511)));
   endtask

   task automatic read_byte(input int idx);
      send_req(ACT_READ, 8'($urandom_range(0, 255)), 9'(idx));
   endtask

   task automatic release_frame();
      send_req(ACT_RELEASE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
   endtask

   // Builds a frame in stream order; sends up to cut bytes, fewer for sync/length flaws.
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ, input logic [7:0] svc,
                             input logic [15:0] id, input logic [15:0] len,
                             input frame_flaw_type flaw, input int cut);
      logic [7:0]  seq [$];
      logic [15:0] c;
      int          body;
      int          limit;
      seq = {sb.sync_a, sb.sync_b, ver, typ, svc, id[7:0], id[15:8], len[7:0], len[15:8]};
      c = CRC_INIT;
      foreach (seq[i]) begin
         c = sb.crc_next(c, seq[i]);
      end
      body = (flaw == FLAW_NONE || flaw == FLAW_CHECK) ? len : 0;
      seq.push_back(8'h00);
      seq.push_back(8'h00);
      for (int i = 0; i < body; i++) begin
         seq.push_back(8'($urandom_range(0, 255)));
         c = sb.crc_next(c, seq[seq.size() - 1]);
      end
      if (flaw == FLAW_CHECK) begin
         c = c ^ (16'h0001 << $urandom_range(0, 15));
      end
      seq[9] = c[7:0];
      seq[10] = c[15:8];
      limit = seq.size();
      if (flaw == FLAW_SYNC) begin
         seq[1] = sb.sync_b ^ 8'($urandom_range(1, 255));
         limit = 2;
      end else if (flaw == FLAW_LENGTH) begin
         limit = HDR_BYTES;
      end
      if (cut >= 0 && cut < limit) begin
         limit = cut;
      end
      for (int i = 0; i < limit; i++) begin
         push_byte(seq[i]);
      end
   endtask

   task automatic hold_session(input int len);
      int n;
      int pick;
      n = $urandom_range(1, 5);
      repeat (n) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            if (len > 0 && $urandom_range(0, 1) == 1) begin
               read_byte($urandom_range(0, len - 1));
            end else begin
               read_byte($urandom_range(0, 511));
            end
         end else if (pick <= 7) begin
            push_byte(8'($urandom_range(0, 255)));
         end else if (pick == 8) begin
            send_req(ACT_NONE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
         end else begin
            read_byte(len);
         end
      end
      if ($urandom_range(0, 19) != 0) begin
         release_frame();
      end
   endtask

   task automatic write_reg(input logic addr, input logic [7:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(addr, value);
   endtask

   task automatic run_traffic(input int target);
      int pick;
      int len;
      while (items_sent < target) begin
         quiet = ($urandom_range(0, 7) == 0);
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 39) == 0) begin
            len = $urandom_range(0, MAX_PAYLOAD);
         end else begin
            len = $urandom_range(0, 12);
         end
         if (pick < 55) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'(len),
                       FLAW_NONE, -1);
            hold_session(len);
         end else if (pick < 70) begin
            case ($urandom_range(0, 2))
               0: send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                             16'(len), FLAW_CHECK, -1);
               1: send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                             16'(len), FLAW_SYNC, -1);
               default: send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                                   16'($urandom_range(MAX_PAYLOAD + 1, 65535)),
                                   FLAW_LENGTH, -1);
            endcase
         end else if (pick < 80) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'(len),
                       FLAW_NONE, $urandom_range(1, HDR_BYTES + len - 1));
            if ($urandom_range(0, 3) != 0) begin
               release_frame();
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        9'($urandom_range(0, 511)));
            end
            if ($urandom_range(0, 9) < 7) begin
               release_frame();
            end
         end
      end
   endtask

   initial begin
      int chunk;
      logic [7:0] first_vals [4];
      logic [7:0] second_vals [4];
      sb = new();
      first_vals = '{8'h00, 8'hFF, 8'h5A, 8'($urandom_range(0, 255))};
      second_vals = '{8'hFF, 8'h00, 8'h5A, 8'($urandom_range(0, 255))};
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= ACT_PUSH;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= CSR_FIRST_SYNC;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_req(ACT_NONE, 8'hFF, 9'h1FF);
      send_req(ACT_READ, 8'h00, 9'd0);
      release_frame();
      send_frame(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'd0, FLAW_NONE, -1);
      read_byte(0);
      push_byte(8'hAA);
      release_frame();
      send_frame(8'h00, 8'hFF, 8'h00, 16'h0000, 16'd3, FLAW_NONE, -1);
      read_byte(0);
      read_byte(2);
      read_byte(3);
      read_byte(511);
      release_frame();
      send_frame(8'h12, 8'h34, 8'h56, 16'h789A, 16'd1, FLAW_SYNC, -1);
      send_frame(8'h12, 8'h34, 8'h56, 16'h789A, 16'd2, FLAW_CHECK, -1);
      send_frame(8'h12, 8'h34, 8'h56, 16'h789A, 16'(MAX_PAYLOAD + 1), FLAW_LENGTH, -1);
      send_frame(8'h12, 8'h34, 8'h56, 16'h789A, 16'hFFFF, FLAW_LENGTH, -1);
      send_frame(8'h12, 8'h34, 8'h56, 16'h789A, 16'd5, FLAW_NONE, 8);
      release_frame();
      send_frame(8'hA5, 8'h5A, 8'hC3, 16'h1234, 16'(MAX_PAYLOAD), FLAW_NONE, -1);
      read_byte(MAX_PAYLOAD - 1);
      read_byte(MAX_PAYLOAD);
      read_byte(0);
      release_frame();

      chunk = (ITEM_GOAL - items_sent) / 4;
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_FIRST_SYNC, first_vals[p]);
         write_reg(CSR_SECOND_SYNC, second_vals[p]);
         run_traffic(items_sent + chunk);
      end

      quiet = 1'b0;
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.leftover_check();
      if (sb.errors == 0) begin
         $display("sync_framed_packet_receiver_tb: done, clean");
      end else begin
         $display("sync_framed_packet_receiver_tb: done, errors");
      end
      $finish;
   end

   initial begin
      int hold_off;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         hold_off = quiet ? 0 : $urandom_range(0, 4);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tuser, rsp_tdata);
      end
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sfpr_pkg.sv
hw/rtl/sfpr_ram.sv
hw/rtl/sync_framed_packet_receiver.sv
bench/sync_framed_packet_receiver_tb.sv
